>>> sv/esae_pkg.sv
package esae_pkg;

    localparam int WindowLenDef  = 8;
    localparam int QueueDepthDef = 2;
    localparam int AddrW         = 5;

    localparam logic [2:0] RegOverflowSpan    = 3'd0;
    localparam logic [2:0] RegReloadValue     = 3'd1;
    localparam logic [2:0] RegVelocityGain    = 3'd2;
    localparam logic [2:0] RegAngleGain       = 3'd3;
    localparam logic [2:0] RegInvertDirection = 3'd4;

    localparam logic [16:0] SpanRst   = 17'd65535;
    localparam logic [15:0] ReloadRst = 16'd65535;
    localparam logic [31:0] GainRst   = 32'd65536;

    localparam logic KindTick     = 1'b0;
    localparam logic KindOverflow = 1'b1;

    localparam logic [31:0] Max32 = 32'h7FFF_FFFF;
    localparam logic [31:0] Min32 = 32'h8000_0000;
    localparam logic [47:0] Max48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Min48 = 48'h8000_0000_0000;

    typedef struct packed {
        logic [16:0] overflow_span;
        logic [15:0] reload_value;
        logic [31:0] velocity_gain;
        logic [31:0] angle_gain;
        logic        invert_direction;
    } cfg_t;

    typedef struct packed {
        logic [15:0] counter_value;
        logic [31:0] overflow_count;
    } tick_word_t;

endpackage

>>> sv/esae_front.sv
module esae_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            reload_value,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic                   kind,
    input  logic [15:0]            counter_value,
    input  logic                   full,
    output logic                   push,
    output esae_pkg::tick_word_t   word
);

    logic [31:0] ovf_reg;
    logic [31:0] ovf_next;
    logic        accept;
    logic [15:0] half;

    assign item_ready = !full;
    assign accept     = item_valid && item_ready;
    assign half       = reload_value >> 1;
    assign push       = accept && (kind == esae_pkg::KindTick);

    assign word.counter_value  = counter_value;
    assign word.overflow_count = ovf_reg;

    // overflow direction from the counter position against half the reload
    always_comb
    begin
        ovf_next = ovf_reg;
        if (accept && (kind == esae_pkg::KindOverflow))
        begin
            if (counter_value > half)
                ovf_next = ovf_reg - 32'd1;
            else
                ovf_next = ovf_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_reg <= '0;
        else
            ovf_reg <= ovf_next;
    end

endmodule

>>> sv/esae_queue.sv
module esae_queue #(
    parameter int DEPTH = esae_pkg::QueueDepthDef
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  esae_pkg::tick_word_t   wdata,
    output logic                   full,
    input  logic                   pop,
    output esae_pkg::tick_word_t   rdata,
    output logic                   empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    esae_pkg::tick_word_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> sv/esae_back.sv
module esae_back #(
    parameter int WINDOW_LEN = esae_pkg::WindowLenDef
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  esae_pkg::cfg_t         cfg,
    input  esae_pkg::tick_word_t   word,
    input  logic                   word_valid,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic signed [31:0]     count_delta,
    output logic signed [31:0]     velocity_avg,
    output logic signed [47:0]     angle_q16
);

    localparam int SW  = 32 + $clog2(WINDOW_LEN);
    localparam int LW  = $clog2(WINDOW_LEN);
    localparam int RS  = SW + LW;
    localparam int MW  = SW + 1;
    localparam int MLW = 20;
    localparam int MHW = MW - MLW;
    localparam int PW  = SW + MW;
    localparam logic [63:0] RecipFull = ((64'd1 << RS) + 64'(WINDOW_LEN) - 64'd1)
                                        / 64'(WINDOW_LEN);
    localparam logic [MW-1:0]  Recip   = RecipFull[MW-1:0];
    localparam logic [MLW-1:0] RecipLo = Recip[MLW-1:0];
    localparam logic [MHW-1:0] RecipHi = Recip[MW-1:MLW];

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MUL   = 11'b000_0000_0010,
        S_EXT   = 11'b000_0000_0100,
        S_DELTA = 11'b000_0000_1000,
        S_GAIN  = 11'b000_0001_0000,
        S_SCALE = 11'b000_0010_0000,
        S_ACC   = 11'b000_0100_0000,
        S_PREP  = 11'b000_1000_0000,
        S_RLO   = 11'b001_0000_0000,
        S_RHI   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [15:0]        cnt_reg;
    logic [31:0]        ovf_reg;
    logic signed [49:0] prod_reg;
    logic [47:0]        ext_reg;
    logic [47:0]        last_reg;
    logic [31:0]        delta_reg;
    logic               neg_reg;
    logic [31:0]        mag_reg;
    logic [63:0]        vprod_reg;
    logic [63:0]        aprod_reg;
    logic [31:0]        vel_reg;
    logic [47:0]        inc_reg;
    logic [31:0]        win_reg [WINDOW_LEN];
    logic [SW-1:0]      sum_reg;
    logic [47:0]        angle_reg;
    logic [SW-1:0]      dmag_reg;
    logic [SW+MLW-1:0]  plo_reg;
    logic [PW-1:0]      rprod_reg;
    logic               sneg_reg;
    logic               result_valid_reg;
    logic [31:0]        count_delta_reg;
    logic [31:0]        velocity_avg_reg;
    logic [47:0]        angle_q16_reg;

    logic [47:0]       raw;
    logic [31:0]       delta_next;
    logic [31:0]       mag_next;
    logic [47:0]       q48;
    logic [31:0]       vel_sgn;
    logic [31:0]       vel_next;
    logic [47:0]       inc_sgn;
    logic [47:0]       inc_next;
    logic [SW-1:0]     sum_next;
    logic [48:0]       angle_wide;
    logic [47:0]       angle_next;
    logic [SW-1:0]     sum_abs;
    logic [SW+MHW-1:0] phi;
    logic [31:0]       quo;
    logic [31:0]       avg_next;
    logic              out_free;

    assign pop      = (state_reg == S_IDLE) && word_valid;
    assign out_free = !result_valid_reg || result_ready;

    // extended count change, saturated to 32 bits
    assign raw = ext_reg - last_reg;
    always_comb
    begin
        if (!raw[47] && (|raw[46:31]))
            delta_next = esae_pkg::Max32;
        else if (raw[47] && !(&raw[46:31]))
            delta_next = esae_pkg::Min32;
        else
            delta_next = raw[31:0];
        mag_next = delta_next[31] ? (~delta_next + 32'd1) : delta_next;
    end

    // velocity from truncated magnitude
    assign q48 = vprod_reg[63:16];
    always_comb
    begin
        if (neg_reg)
            vel_sgn = ((|q48[47:32]) || (q48[31] && (|q48[30:0]))) ? esae_pkg::Min32
                                                                   : (~q48[31:0] + 32'd1);
        else
            vel_sgn = (|q48[47:31]) ? esae_pkg::Max32 : q48[31:0];
        if (cfg.invert_direction)
            vel_next = (vel_sgn == esae_pkg::Min32) ? esae_pkg::Max32 : (~vel_sgn + 32'd1);
        else
            vel_next = vel_sgn;
    end

    // angle increment
    always_comb
    begin
        if (neg_reg)
            inc_sgn = ((|aprod_reg[63:48]) || (aprod_reg[47] && (|aprod_reg[46:0])))
                      ? esae_pkg::Min48 : (~aprod_reg[47:0] + 48'd1);
        else
            inc_sgn = (|aprod_reg[63:47]) ? esae_pkg::Max48 : aprod_reg[47:0];
        if (cfg.invert_direction)
            inc_next = (inc_sgn == esae_pkg::Min48) ? esae_pkg::Max48 : (~inc_sgn + 48'd1);
        else
            inc_next = inc_sgn;
    end

    always_comb
    begin
        sum_next   = sum_reg - SW'($signed(win_reg[WINDOW_LEN-1])) + SW'($signed(vel_reg));
        angle_wide = {angle_reg[47], angle_reg} + {inc_reg[47], inc_reg};
        if (angle_wide[48] != angle_wide[47])
            angle_next = angle_wide[48] ? esae_pkg::Min48 : esae_pkg::Max48;
        else
            angle_next = angle_wide[47:0];
    end

    // average by reciprocal multiplication, exact over the whole sum range
    assign sum_abs  = sum_reg[SW-1] ? (~sum_reg + SW'(1)) : sum_reg;
    assign phi      = dmag_reg * RecipHi;
    assign quo      = rprod_reg[RS+31:RS];
    assign avg_next = sneg_reg ? (~quo + 32'd1) : quo;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (word_valid) state_next = S_MUL;
            S_MUL:   state_next = S_EXT;
            S_EXT:   state_next = S_DELTA;
            S_DELTA: state_next = S_GAIN;
            S_GAIN:  state_next = S_SCALE;
            S_SCALE: state_next = S_ACC;
            S_ACC:   state_next = S_PREP;
            S_PREP:  state_next = S_RLO;
            S_RLO:   state_next = S_RHI;
            S_RHI:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            last_reg         <= '0;
            sum_reg          <= '0;
            angle_reg        <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DELTA)
                last_reg <= ext_reg;
            if (state_reg == S_ACC)
            begin
                sum_reg   <= sum_next;
                angle_reg <= angle_next;
                win_reg[0] <= vel_reg;
                for (int i = 1; i < WINDOW_LEN; i++)
                    win_reg[i] <= win_reg[i-1];
            end
            if ((state_reg == S_DONE) && out_free)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cnt_reg <= word.counter_value;
            ovf_reg <= word.overflow_count;
        end
        if (state_reg == S_MUL)
            prod_reg <= $signed(ovf_reg) * $signed({1'b0, cfg.overflow_span});
        if (state_reg == S_EXT)
            ext_reg <= prod_reg[47:0] + {32'd0, cnt_reg};
        if (state_reg == S_DELTA)
        begin
            delta_reg <= delta_next;
            neg_reg   <= delta_next[31];
            mag_reg   <= mag_next;
        end
        if (state_reg == S_GAIN)
        begin
            vprod_reg <= mag_reg * cfg.velocity_gain;
            aprod_reg <= mag_reg * cfg.angle_gain;
        end
        if (state_reg == S_SCALE)
        begin
            vel_reg <= vel_next;
            inc_reg <= inc_next;
        end
        if (state_reg == S_PREP)
        begin
            sneg_reg <= sum_reg[SW-1];
            dmag_reg <= sum_abs;
        end
        if (state_reg == S_RLO)
            plo_reg <= dmag_reg * RecipLo;
        if (state_reg == S_RHI)
            rprod_reg <= {phi, {MLW{1'b0}}} + PW'(plo_reg);
        if ((state_reg == S_DONE) && out_free)
        begin
            count_delta_reg  <= delta_reg;
            velocity_avg_reg <= avg_next;
            angle_q16_reg    <= angle_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign count_delta  = $signed(count_delta_reg);
    assign velocity_avg = $signed(velocity_avg_reg);
    assign angle_q16    = $signed(angle_q16_reg);

    ap_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    ap_sum_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RLO) || (state_reg == S_RHI)) |-> (sneg_reg == sum_reg[SW-1]))
        else $error("window sum changed during averaging");

    ap_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !rprod_reg[PW-1])
        else $error("average quotient out of range");

    ap_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && result_valid && !result_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");

endmodule

>>> sv/encoder_speed_angle_estimator.sv
// overflow words: accepted one per cycle while the tick queue has room, no result
// tick words: one result each, offered once the back sequencer has stepped through
// multiplies, saturation, window update and a two-step reciprocal multiply for the
// average; the next tick is taken from the queue only after that result is offered
// a two-entry tick queue lets overflow words keep flowing while a tick is worked on
// reset (async, active low) restores register defaults and clears counts, window and angle
module encoder_speed_angle_estimator #(
    parameter int WINDOW_LEN  = esae_pkg::WindowLenDef,
    parameter int QUEUE_DEPTH = esae_pkg::QueueDepthDef
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esae_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        kind,
    input  logic [15:0]                 counter_value,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [31:0]          count_delta,
    output logic signed [31:0]          velocity_avg,
    output logic signed [47:0]          angle_q16
);

    esae_pkg::cfg_t       cfg_reg;
    esae_pkg::tick_word_t push_word;
    esae_pkg::tick_word_t pop_word;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[esae_pkg::AddrW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overflow_span    <= esae_pkg::SpanRst;
            cfg_reg.reload_value     <= esae_pkg::ReloadRst;
            cfg_reg.velocity_gain    <= esae_pkg::GainRst;
            cfg_reg.angle_gain       <= esae_pkg::GainRst;
            cfg_reg.invert_direction <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                esae_pkg::RegOverflowSpan:    cfg_reg.overflow_span    <= pwdata[16:0];
                esae_pkg::RegReloadValue:     cfg_reg.reload_value     <= pwdata[15:0];
                esae_pkg::RegVelocityGain:    cfg_reg.velocity_gain    <= pwdata;
                esae_pkg::RegAngleGain:       cfg_reg.angle_gain       <= pwdata;
                esae_pkg::RegInvertDirection: cfg_reg.invert_direction <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            esae_pkg::RegOverflowSpan:    prdata = {15'd0, cfg_reg.overflow_span};
            esae_pkg::RegReloadValue:     prdata = {16'd0, cfg_reg.reload_value};
            esae_pkg::RegVelocityGain:    prdata = cfg_reg.velocity_gain;
            esae_pkg::RegAngleGain:       prdata = cfg_reg.angle_gain;
            esae_pkg::RegInvertDirection: prdata = {31'd0, cfg_reg.invert_direction};
            default:                      prdata = '0;
        endcase
    end

    esae_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .reload_value  (cfg_reg.reload_value),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .counter_value (counter_value),
        .full          (full),
        .push          (push),
        .word          (push_word)
    );

    esae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_word),
        .full  (full),
        .pop   (pop),
        .rdata (pop_word),
        .empty (empty)
    );

    esae_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .word         (pop_word),
        .word_valid   (!empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .count_delta  (count_delta),
        .velocity_avg (velocity_avg),
        .angle_q16    (angle_q16)
    );

endmodule
